>>> design/ofc_pkg.sv
// Shared types, widths, codes and the CORDIC angle table of the flow colorizer.
`default_nettype none
package ofc_pkg;

    localparam int FLOW_W       = 16;
    localparam int TBL_DEPTH    = 64;
    localparam int TBL_AW       = $clog2(TBL_DEPTH);
    localparam int N_W          = TBL_AW + 1;
    localparam int TURN_BITS    = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int CX_W         = FLOW_W + 10;
    localparam int Z_W          = TURN_BITS + 1;
    localparam int S_W          = 2 * FLOW_W;
    localparam int RAD_W        = S_W + 16;
    localparam int RT_W         = RAD_W / 2;
    localparam int REM_W        = RT_W + 2;
    localparam int JW           = $clog2(RT_W);
    localparam int M_W          = 15;
    localparam int MM_W         = 2 * M_W;
    localparam int Q_W          = 9;
    localparam int QB_W         = 4;
    localparam int POS_W        = TURN_BITS + TBL_AW - (TURN_BITS - 8);

    localparam logic [TURN_BITS-2:0] QUARTER = (TURN_BITS-1)'(1 << (TURN_BITS - 2));
    localparam logic [TURN_BITS:0]   HALF    = (TURN_BITS+1)'(1 << (TURN_BITS - 1));
    localparam logic [TURN_BITS:0]   FULL    = (TURN_BITS+1)'(1 << TURN_BITS);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [1:0] CFG_WHEEL  = 2'd0;
    localparam logic [1:0] CFG_MOTION = 2'd1;
    localparam logic [1:0] CFG_ALPHA  = 2'd2;
    localparam int CFG_DW = 15;

    typedef struct packed {
        logic                     req_type;
        logic [5:0]               table_index;
        logic [7:0]               table_red;
        logic [7:0]               table_green;
        logic [7:0]               table_blue;
        logic signed [FLOW_W-1:0] flow_u;
        logic signed [FLOW_W-1:0] flow_v;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
    } t_out_word;

    // One word in flight through the cell chain.
    typedef struct packed {
        logic                   valid;
        logic                   pix;
        logic [5:0]             lidx;
        logic [23:0]            lrgb;
        logic                   usgn;
        logic                   vsgn;
        logic                   axz;
        logic                   ayz;
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [Z_W-1:0]  cz;
        logic [S_W-1:0]         s;
        logic                   in_rad;
        logic [RT_W-1:0]        rt;
        logic [REM_W-1:0]       rem;
        logic [RT_W-1:0]        drem;
        logic [Q_W-1:0]         q;
    } t_tok;

    function automatic logic [Z_W-2:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [Z_W-2:0] r;
        begin
            case (i)
                4'd0:    r = 20'd131072;
                4'd1:    r = 20'd77376;
                4'd2:    r = 20'd40884;
                4'd3:    r = 20'd20753;
                4'd4:    r = 20'd10417;
                4'd5:    r = 20'd5213;
                4'd6:    r = 20'd2607;
                4'd7:    r = 20'd1304;
                4'd8:    r = 20'd652;
                4'd9:    r = 20'd326;
                4'd10:   r = 20'd163;
                4'd11:   r = 20'd81;
                4'd12:   r = 20'd41;
                4'd13:   r = 20'd20;
                4'd14:   r = 20'd10;
                default: r = 20'd5;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/optical_flow_colorizer_core.sv
// Top level of the optical flow colorizer: cell chain, color wheel and output stage.
//
// Input channel: i_valid / o_in_stall carry one t_in_word per accepted word.
// A load word (req_type 0) writes one RGB entry of the color wheel; a pixel
// word (req_type 1) carries a flow vector (u,v) in signed Q10.6 and yields one
// output word on o_valid / i_stall. Loads yield nothing.
// Configuration: i_cfg_we writes register i_cfg_idx (0 wheel entries,
// 1 max motion, 2 alpha enable) with i_cfg_data.
// Throughput: one word per cycle while the output is not stalled. The pipeline has
// 58 register stages: the chain of 16 CORDIC cells, 24 square-root cells and 9
// divider cells plus input, magnitude, radius, angle-fold, wheel-position,
// neighbor-index, table-read, blend and output registers.
// Loads travel down the chain with the pixels and write the table at the same
// stage where pixels read it, so table updates keep word order.
// Reset clears all valid bits and restores the register defaults; the table
// holds garbage until loaded. When the receiver stalls a valid output word,
// the whole chain freezes and o_in_stall rises in the same cycle.
`default_nettype none
module optical_flow_colorizer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_in_stall,
    input  wire ofc_pkg::t_in_word             i_in_word,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output ofc_pkg::t_out_word                 o_out_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_idx,
    input  wire logic [ofc_pkg::CFG_DW-1:0]    i_cfg_data
);
    localparam int NCOR = ofc_pkg::CORDIC_STEPS;
    localparam int NSQ  = ofc_pkg::RT_W;
    localparam int NDIV = ofc_pkg::Q_W;

    // configuration
    logic [6:0]              r_wheel;
    logic [ofc_pkg::M_W-1:0] r_motion;
    logic                    r_alpha;
    logic [ofc_pkg::N_W-1:0] n_eff;
    logic [ofc_pkg::M_W-1:0] m_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel  <= 7'd55;
            r_motion <= 15'd64;
            r_alpha  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ofc_pkg::CFG_WHEEL:  r_wheel  <= i_cfg_data[6:0];
                ofc_pkg::CFG_MOTION: r_motion <= i_cfg_data[ofc_pkg::M_W-1:0];
                ofc_pkg::CFG_ALPHA:  r_alpha  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the wheel size to 1..depth and the normalizer to at least 1
    always_comb begin
        if (r_wheel == 7'd0)
            n_eff = ofc_pkg::N_W'(1);
        else if (r_wheel > 7'(ofc_pkg::TBL_DEPTH))
            n_eff = ofc_pkg::N_W'(ofc_pkg::TBL_DEPTH);
        else
            n_eff = ofc_pkg::N_W'(r_wheel);
        m_eff = (r_motion == '0) ? ofc_pkg::M_W'(1) : r_motion;
    end

    // global advance: freeze everything while a finished word is held
    logic adv;
    assign adv        = !o_valid || !i_stall;
    assign o_in_stall = !adv;

    // input register
    logic              r_s0_valid;
    ofc_pkg::t_in_word r_s0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_valid;
            r_s0       <= i_in_word;
        end
    end

    // stage 1: magnitudes, squares, CORDIC start vector
    logic [ofc_pkg::FLOW_W-1:0] ax;
    logic [ofc_pkg::FLOW_W-1:0] ay;
    ofc_pkg::t_tok              n_s1;
    ofc_pkg::t_tok              r_s1;
    logic [ofc_pkg::S_W-1:0]    r_squ;
    logic [ofc_pkg::S_W-1:0]    r_sqv;
    logic [ofc_pkg::MM_W-1:0]   r_mm;

    always_comb begin
        ax = r_s0.flow_u[ofc_pkg::FLOW_W-1] ? ofc_pkg::FLOW_W'(-r_s0.flow_u) : r_s0.flow_u;
        ay = r_s0.flow_v[ofc_pkg::FLOW_W-1] ? ofc_pkg::FLOW_W'(-r_s0.flow_v) : r_s0.flow_v;
        n_s1        = '0;
        n_s1.valid  = r_s0_valid;
        n_s1.pix    = (r_s0.req_type == ofc_pkg::REQ_PIXEL);
        n_s1.lidx   = r_s0.table_index;
        n_s1.lrgb   = {r_s0.table_red, r_s0.table_green, r_s0.table_blue};
        n_s1.usgn   = r_s0.flow_u[ofc_pkg::FLOW_W-1];
        n_s1.vsgn   = r_s0.flow_v[ofc_pkg::FLOW_W-1];
        n_s1.axz    = (ax == '0);
        n_s1.ayz    = (ay == '0);
        n_s1.cx     = ofc_pkg::CX_W'({ax, 8'b0});
        n_s1.cy     = ofc_pkg::CX_W'({ay, 8'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (adv) begin
            r_s1  <= n_s1;
            r_squ <= ofc_pkg::S_W'(ax * ax);
            r_sqv <= ofc_pkg::S_W'(ay * ay);
            r_mm  <= ofc_pkg::MM_W'(m_eff * m_eff);
        end
    end

    // stage 2: squared radius and the unit circle test
    ofc_pkg::t_tok n_s2;
    ofc_pkg::t_tok r_s2;
    always_comb begin
        n_s2        = r_s1;
        n_s2.s      = r_squ + r_sqv;
        n_s2.in_rad = (n_s2.s <= ofc_pkg::S_W'(r_mm));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (adv) begin
            r_s2 <= n_s2;
        end
    end

    // cell chains: phase, root, quotient
    ofc_pkg::t_tok w_cor [NCOR+1];
    ofc_pkg::t_tok w_sq  [NSQ+1];
    ofc_pkg::t_tok w_div [NDIV+1];
    ofc_pkg::t_tok div_in;

    assign w_cor[0] = r_s2;
    assign w_sq[0]  = w_cor[NCOR];

    // the root becomes the dividend of the quotient chain
    always_comb begin
        div_in      = w_sq[NSQ];
        div_in.drem = w_sq[NSQ].rt;
    end

    assign w_div[0] = div_in;

    for (genvar gi = 0; gi < NCOR; gi++) begin : g_cor
        ofc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_step  (ofc_pkg::STEP_W'(gi)),
            .i_tok   (w_cor[gi]),
            .o_tok   (w_cor[gi+1])
        );
    end

    for (genvar gk = 0; gk < NSQ; gk++) begin : g_sq
        ofc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_digit (ofc_pkg::JW'(NSQ - 1 - gk)),
            .i_tok   (w_sq[gk]),
            .o_tok   (w_sq[gk+1])
        );
    end

    for (genvar gd = 0; gd < NDIV; gd++) begin : g_div
        ofc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_bit   (ofc_pkg::QB_W'(NDIV - 1 - gd)),
            .i_m     (m_eff),
            .i_tok   (w_div[gd]),
            .o_tok   (w_div[gd+1])
        );
    end

    // stage P: clamp the angle and fold it into a full turn
    ofc_pkg::t_tok               tk;
    logic [ofc_pkg::TURN_BITS-2:0] ang;
    logic [ofc_pkg::TURN_BITS:0]   t_full;
    logic                          r_p_valid;
    logic                          r_p_pix;
    logic [5:0]                    r_p_lidx;
    logic [23:0]                   r_p_lrgb;
    logic                          r_p_inside;
    logic [ofc_pkg::Q_W-1:0]       r_p_q;
    logic [ofc_pkg::TURN_BITS-1:0] r_p_t;

    assign tk = w_div[NDIV];

    always_comb begin
        if (tk.ayz)
            ang = '0;
        else if (tk.axz)
            ang = ofc_pkg::QUARTER;
        else if (tk.cz[ofc_pkg::Z_W-1])
            ang = '0;
        else if (tk.cz[ofc_pkg::Z_W-2:0] > (ofc_pkg::Z_W-1)'(ofc_pkg::QUARTER))
            ang = ofc_pkg::QUARTER;
        else
            ang = tk.cz[ofc_pkg::TURN_BITS-2:0];

        if (!tk.usgn && !tk.vsgn)
            t_full = (ofc_pkg::TURN_BITS+1)'(ang);
        else if (tk.usgn && !tk.vsgn)
            t_full = ofc_pkg::HALF - (ofc_pkg::TURN_BITS+1)'(ang);
        else if (tk.usgn)
            t_full = ofc_pkg::HALF + (ofc_pkg::TURN_BITS+1)'(ang);
        else
            t_full = ofc_pkg::FULL - (ofc_pkg::TURN_BITS+1)'(ang);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid  <= tk.valid;
            r_p_pix    <= tk.pix;
            r_p_lidx   <= tk.lidx;
            r_p_lrgb   <= tk.lrgb;
            r_p_inside <= tk.in_rad;
            r_p_q      <= tk.q;
            r_p_t      <= t_full[ofc_pkg::TURN_BITS-1:0];
        end
    end

    // stage Q: wheel position in Q.8
    logic [ofc_pkg::TBL_AW-1:0]        nm1;
    logic [ofc_pkg::TURN_BITS+ofc_pkg::TBL_AW-1:0] prod;
    logic                              r_q_valid;
    logic                              r_q_pix;
    logic [5:0]                        r_q_lidx;
    logic [23:0]                       r_q_lrgb;
    logic                              r_q_inside;
    logic [ofc_pkg::Q_W-1:0]           r_q_q;
    logic [ofc_pkg::POS_W-1:0]         r_q_pos;

    assign nm1  = ofc_pkg::TBL_AW'(n_eff - ofc_pkg::N_W'(1));
    assign prod = r_p_t * nm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
        end else if (adv) begin
            r_q_valid  <= r_p_valid;
            r_q_pix    <= r_p_pix;
            r_q_lidx   <= r_p_lidx;
            r_q_lrgb   <= r_p_lrgb;
            r_q_inside <= r_p_inside;
            r_q_q      <= r_p_q;
            r_q_pos    <= prod[ofc_pkg::TURN_BITS+ofc_pkg::TBL_AW-1:ofc_pkg::TURN_BITS-8];
        end
    end

    // stage R: neighbor entries, wrapping past the last one
    logic [ofc_pkg::N_W-1:0]    k0w;
    logic [ofc_pkg::N_W-1:0]    k1w;
    logic                       r_r_valid;
    logic                       r_r_pix;
    logic [5:0]                 r_r_lidx;
    logic [23:0]                r_r_lrgb;
    logic                       r_r_inside;
    logic [ofc_pkg::Q_W-1:0]    r_r_q;
    logic [7:0]                 r_r_f;
    logic [ofc_pkg::TBL_AW-1:0] r_k0;
    logic [ofc_pkg::TBL_AW-1:0] r_k1;

    always_comb begin
        k0w = ofc_pkg::N_W'(r_q_pos[ofc_pkg::POS_W-1:8]);
        if (k0w >= n_eff)
            k0w = n_eff - ofc_pkg::N_W'(1);
        k1w = k0w + ofc_pkg::N_W'(1);
        if (k1w >= n_eff)
            k1w = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (adv) begin
            r_r_valid  <= r_q_valid;
            r_r_pix    <= r_q_pix;
            r_r_lidx   <= r_q_lidx;
            r_r_lrgb   <= r_q_lrgb;
            r_r_inside <= r_q_inside;
            r_r_q      <= r_q_q;
            r_r_f      <= r_q_pos[7:0];
            r_k0       <= k0w[ofc_pkg::TBL_AW-1:0];
            r_k1       <= k1w[ofc_pkg::TBL_AW-1:0];
        end
    end

    // stage T: color wheel memory, loads write here in word order
    logic [23:0]             r_mem [ofc_pkg::TBL_DEPTH];
    logic [23:0]             r_e0;
    logic [23:0]             r_e1;
    logic                    r_t_valid;
    logic                    r_t_pix;
    logic                    r_t_inside;
    logic [ofc_pkg::Q_W-1:0] r_t_q;
    logic [7:0]              r_t_f;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_r_valid && !r_r_pix)
                r_mem[r_r_lidx[ofc_pkg::TBL_AW-1:0]] <= r_r_lrgb;
            r_e0 <= r_mem[r_k0];
            r_e1 <= r_mem[r_k1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (adv) begin
            r_t_valid  <= r_r_valid;
            r_t_pix    <= r_r_pix;
            r_t_inside <= r_r_inside;
            r_t_q      <= r_r_q;
            r_t_f      <= r_r_f;
        end
    end

    // stage U: linear blend of the two neighbors, Q.8
    logic [8:0]  wf0;
    logic [16:0] n_c8 [3];
    logic [16:0] r_c8 [3];
    logic        r_u_valid;
    logic        r_u_pix;
    logic        r_u_inside;
    logic [ofc_pkg::Q_W-1:0] r_u_q;

    assign wf0 = 9'd256 - 9'(r_t_f);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_c8[ch] = 17'(wf0 * r_e0[16-8*ch +: 8]) + 17'(r_t_f * r_e1[16-8*ch +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid <= 1'b0;
        end else if (adv) begin
            r_u_valid  <= r_t_valid;
            r_u_pix    <= r_t_pix;
            r_u_inside <= r_t_inside;
            r_u_q      <= r_t_q;
            r_c8       <= n_c8;
        end
    end

    // output stage: desaturate inside the unit circle, dim outside
    logic [25:0] desat [3];
    logic [18:0] dim   [3];
    logic [7:0]  chan  [3];
    ofc_pkg::t_out_word n_out;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            desat[ch] = 26'd16711680 - 26'(r_u_q * (17'd65280 - r_c8[ch]));
            dim[ch]   = 19'(r_c8[ch] * 2'd3);
            chan[ch]  = r_u_inside ? desat[ch][23:16] : dim[ch][17:10];
        end
        n_out.red       = chan[0];
        n_out.green     = chan[1];
        n_out.blue      = chan[2];
        n_out.alpha     = r_alpha ? 8'hFF : 8'h00;
        n_out.has_alpha = r_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid    <= r_u_valid && r_u_pix;
            o_out_word <= n_out;
        end
    end

    // input stalls only behind a held output word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output word");

    // alpha field agrees with its flag
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_word.alpha == (o_out_word.has_alpha ? 8'hFF : 8'h00)))
        else $error("alpha field disagrees with has_alpha");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire

>>> design/ofc_cordic_cell.sv
// One vectoring CORDIC iteration of the phase chain.
`default_nettype none
module ofc_cordic_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic [ofc_pkg::STEP_W-1:0]    i_step,
    input  wire ofc_pkg::t_tok                 i_tok,
    output ofc_pkg::t_tok                      o_tok
);
    ofc_pkg::t_tok r_tok;
    ofc_pkg::t_tok n_tok;
    logic signed [ofc_pkg::CX_W-1:0] dx;
    logic signed [ofc_pkg::CX_W-1:0] dy;
    logic signed [ofc_pkg::Z_W-1:0]  da;

    always_comb begin
        n_tok = i_tok;
        dx    = i_tok.cy >>> i_step;
        dy    = i_tok.cx >>> i_step;
        da    = $signed({1'b0, ofc_pkg::atan_turn(i_step)});
        // rotate toward the x axis
        if (!i_tok.cy[ofc_pkg::CX_W-1]) begin
            n_tok.cx = i_tok.cx + dx;
            n_tok.cy = i_tok.cy - dy;
            n_tok.cz = i_tok.cz + da;
        end else begin
            n_tok.cx = i_tok.cx - dx;
            n_tok.cy = i_tok.cy + dy;
            n_tok.cz = i_tok.cz - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

>>> design/ofc_sqrt_cell.sv
// One result bit of the digit-by-digit square root of the squared radius.
`default_nettype none
module ofc_sqrt_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [ofc_pkg::JW-1:0]     i_digit,
    input  wire ofc_pkg::t_tok              i_tok,
    output ofc_pkg::t_tok                   o_tok
);
    ofc_pkg::t_tok r_tok;
    ofc_pkg::t_tok n_tok;
    logic [ofc_pkg::RAD_W-1:0] rad;
    logic [ofc_pkg::RAD_W-1:0] sh;
    logic [ofc_pkg::REM_W+1:0] rem2;
    logic [ofc_pkg::REM_W+1:0] trial;

    always_comb begin
        n_tok = i_tok;
        rad   = {i_tok.s, 16'b0};
        sh    = rad >> {i_digit, 1'b0};
        rem2  = {i_tok.rem, sh[1:0]};
        trial = (ofc_pkg::REM_W+2)'({i_tok.rt, 2'b01});
        if (rem2 >= trial) begin
            n_tok.rem = ofc_pkg::REM_W'(rem2 - trial);
            n_tok.rt  = {i_tok.rt[ofc_pkg::RT_W-2:0], 1'b1};
        end else begin
            n_tok.rem = ofc_pkg::REM_W'(rem2);
            n_tok.rt  = {i_tok.rt[ofc_pkg::RT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire

>>> design/ofc_div_cell.sv
// One quotient bit of the radius normalization.
`default_nettype none
module ofc_div_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [ofc_pkg::QB_W-1:0]   i_bit,
    input  wire logic [ofc_pkg::M_W-1:0]    i_m,
    input  wire ofc_pkg::t_tok              i_tok,
    output ofc_pkg::t_tok                   o_tok
);
    ofc_pkg::t_tok r_tok;
    ofc_pkg::t_tok n_tok;
    logic [ofc_pkg::RT_W:0] dv;

    always_comb begin
        n_tok = i_tok;
        dv    = (ofc_pkg::RT_W+1)'(i_m) << i_bit;
        if ({1'b0, i_tok.drem} >= dv) begin
            n_tok.drem     = ofc_pkg::RT_W'({1'b0, i_tok.drem} - dv);
            n_tok.q[i_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
endmodule
`default_nettype wire
